/* rtl/iirlp5_pkg.sv */
`timescale 1ns / 1ps
package iirlp5_pkg;

  localparam int DATA_W     = 8;
  localparam int HIST_DEPTH = 5;
  localparam int COEF_W     = 8;
  // |acc| stays below 384*128, so 18 signed bits leave headroom
  localparam int ACC_W      = 18;
  localparam int FRAC_BITS  = 7;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // Feedforward taps x0..x5 and feedback taps y1..y5, scaled by 128
  localparam coef_t FF_COEF [HIST_DEPTH+1] = '{
    coef_t'(14), coef_t'(28), coef_t'(44), coef_t'(44), coef_t'(28), coef_t'(14)
  };
  localparam coef_t FB_COEF [HIST_DEPTH] = '{
    coef_t'(68), coef_t'(-112), coef_t'(16), coef_t'(-15), coef_t'(-1)
  };

  // Bias that turns an arithmetic shift into truncation toward zero
  localparam acc_t TRUNC_BIAS = acc_t'((1 << FRAC_BITS) - 1);

  // Offset binary <-> two's complement: flip the top bit
  localparam logic [DATA_W-1:0] MID_FLIP = DATA_W'(1) << (DATA_W - 1);

endpackage

/* rtl/iirlp5_cell.sv */
`timescale 1ns / 1ps
// One delay stage: holds x[k] and y[k], forms its share of the sum.
module iirlp5_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  iirlp5_pkg::sample_t x_in,
  input  iirlp5_pkg::sample_t y_in,
  input  iirlp5_pkg::coef_t   ff_coef,
  input  iirlp5_pkg::coef_t   fb_coef,
  output iirlp5_pkg::sample_t x_out,
  output iirlp5_pkg::sample_t y_out,
  output iirlp5_pkg::acc_t    term
);
  import iirlp5_pkg::*;

  sample_t x_r, x_nxt;
  sample_t y_r, y_nxt;
  logic signed [DATA_W+COEF_W-1:0] ff_prod;
  logic signed [DATA_W+COEF_W-1:0] fb_prod;

  always_comb begin
    x_nxt = adv ? x_in : x_r;
    y_nxt = adv ? y_in : y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  assign ff_prod = ff_coef * x_r;
  assign fb_prod = fb_coef * y_r;
  assign term    = acc_t'(ff_prod) + acc_t'(fb_prod);
  assign x_out   = x_r;
  assign y_out   = y_r;

endmodule

/* rtl/iir_lowpass_order5_core.sv */
`timescale 1ns / 1ps
// Fixed 5th-order low-pass IIR filter, direct form I, for an 8-bit converter
// sample stream.
// Input channel: in_valid / in_ready carry in_adc_sample, offset binary with
// midscale 128. Output channel: out_valid / out_ready carry out_dac_value,
// the filtered sample, also offset binary.
// Every input transfer produces exactly one output transfer, in order.
// The result is registered in the output buffer and reaches the output port
// once the head is free. Throughput: one sample per clock while in_ready is
// high; the feedback loop (new output into the first delay cell) closes
// through the multiply-add tree, the divide-by-128 and the history registers.
// A two-entry output buffer (head plus skid register) decouples the sides:
// an input transfer is taken while a result waits, and in_ready drops only
// when both entries are full.
// Reset (rst_n low, synchronous) zeroes all sample and output history and
// empties the output buffer. While the receiver stalls, the result holds
// on the output port and the filter state advances only on input transfers.
module iir_lowpass_order5_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [iirlp5_pkg::DATA_W-1:0] in_adc_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [iirlp5_pkg::DATA_W-1:0] out_dac_value
);
  import iirlp5_pkg::*;

  logic    in_xfer;
  logic    out_xfer;
  sample_t x0;
  sample_t y0;
  acc_t    acc;
  acc_t    acc_adj;

  // Delay line taps: index 0 is the new sample, k is k steps back
  sample_t x_tap [HIST_DEPTH+1];
  sample_t y_tap [HIST_DEPTH+1];
  acc_t    cell_term [HIST_DEPTH];
  acc_t    part_sum  [HIST_DEPTH+1];

  logic                head_v_r, head_v_nxt;
  logic                skid_v_r, skid_v_nxt;
  logic [DATA_W-1:0]   head_r, head_nxt;
  logic [DATA_W-1:0]   skid_r, skid_nxt;
  logic [DATA_W-1:0]   dac_new;

  assign in_ready = !skid_v_r;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = head_v_r && out_ready;

  // Subtract 128: flip the top bit to get the signed sample
  assign x0 = sample_t'(in_adc_sample ^ MID_FLIP);

  assign x_tap[0] = x0;
  assign y_tap[0] = y0;

  // Row of delay cells; each shifts its pair of samples on every transfer
  for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
    iirlp5_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (in_xfer),
      .x_in    (x_tap[k]),
      .y_in    (y_tap[k]),
      .ff_coef (FF_COEF[k+1]),
      .fb_coef (FB_COEF[k]),
      .x_out   (x_tap[k+1]),
      .y_out   (y_tap[k+1]),
      .term    (cell_term[k])
    );
  end

  // Sum the new-sample tap and the cell terms
  always_comb begin
    part_sum[0] = acc_t'(FF_COEF[0] * x0);
    for (int k = 0; k < HIST_DEPTH; k++) begin
      part_sum[k+1] = part_sum[k] + cell_term[k];
    end
  end
  assign acc = part_sum[HIST_DEPTH];

  // Divide by 128 toward zero, keep the low byte (wraps)
  assign acc_adj = acc[ACC_W-1] ? (acc + TRUNC_BIAS) : acc;
  assign y0      = sample_t'(acc_adj[FRAC_BITS +: DATA_W]);
  assign dac_new = DATA_W'(y0) ^ MID_FLIP;

  // Output buffer: head drives the port, skid catches a transfer that
  // arrives while the head is stalled
  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (out_xfer) begin
        head_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (in_xfer) begin
      if (!head_v_r || out_xfer) begin
        head_nxt   = dac_new;
        head_v_nxt = 1'b1;
      end else begin
        skid_nxt   = dac_new;
        skid_v_nxt = 1'b1;
      end
    end else if (out_xfer) begin
      head_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid     = head_v_r;
  assign out_dac_value = head_r;

endmodule
